>>> rtl/kmp_substring_search_top_assert.svh
// ----------------------------------------------------------------------------
// kmp_substring_search_top_assert.svh
// Assertion macros shared by the substring search block.
// ----------------------------------------------------------------------------
`ifndef KMP_SUBSTRING_SEARCH_TOP_ASSERT_SVH
`define KMP_SUBSTRING_SEARCH_TOP_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define KSS_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent must hold at the edge after the antecedent.
`define KSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/kmpss_pkg.sv
// ----------------------------------------------------------------------------
// kmpss_pkg
// Operation and status codes and fixed field widths of the substring search.
// ----------------------------------------------------------------------------
package kmpss_pkg;

    localparam int BYTE_W   = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 32;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_END    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    localparam logic [POS_W-1:0] POS_MAX = '1;

endpackage

>>> rtl/kmpss_ram.sv
// ----------------------------------------------------------------------------
// kmpss_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kmpss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/kmp_substring_search_top.sv
// ----------------------------------------------------------------------------
// kmp_substring_search_top
// First-occurrence Knuth-Morris-Pratt search over a byte stream. Pattern bytes
// and failure links share one RAM word per pattern index.
// ----------------------------------------------------------------------------
// Clear, end of text, an append at the root or past capacity and a text byte
//   that needs no walk finish in their accept cycle; any other item walks in
//   S_CMP, one failure link per cycle through the RAM read port.
// Items are taken one at a time. A result waiting on the receiver holds off
//   an item that decides a result at once; a match held in S_WAIT holds off all.
// Reset (synchronous, active low) empties the pattern; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module kmp_substring_search_top
    import kmpss_pkg::*;
#(
    parameter int MAX_PATTERN = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [BYTE_W-1:0]   i_data_byte,
    // result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [POS_W-1:0]    o_position
);

`include "kmp_substring_search_top_assert.svh"

    // AW indexes the RAM, LW holds a failure link (-1 .. MAX_PATTERN-1),
    // LENW holds a pattern length (0 .. MAX_PATTERN).
    localparam int AW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW   = AW + 1;
    localparam int LENW = $clog2(MAX_PATTERN + 1);
    localparam int DW   = BYTE_W + LW;

    localparam logic [LENW-1:0] LEN_FULL = LENW'(MAX_PATTERN);
    localparam logic [LW-1:0]   LINK_NONE = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_WAIT
    } t_state;

    // ------------------------------------------------------------------
    // Registers and next values
    // ------------------------------------------------------------------
    t_state                   r_state, n_state;
    logic [LENW-1:0]          r_len, n_len;           // pattern length
    logic signed [LW-1:0]     r_build, n_build;       // prefix carried by table build
    logic [AW-1:0]            r_match, n_match;       // matched prefix length
    logic [POS_W-1:0]         r_tpos, n_tpos;         // text bytes seen, saturating
    logic                     r_reported, n_reported;
    logic [BYTE_W-1:0]        r_last_byte, n_last_byte;
    logic [BYTE_W-1:0]        r_cmp_byte, n_cmp_byte; // byte the walk compares
    logic [BYTE_W-1:0]        r_new_byte, n_new_byte; // byte an append stores
    logic                     r_is_append, n_is_append;
    logic [AW-1:0]            r_k, n_k;               // walk index
    logic [POS_W-1:0]         r_found_pos, n_found_pos;
    logic                     r_out_valid, n_out_valid;
    t_status                  r_out_status, n_out_status;
    logic [POS_W-1:0]         r_out_pos, n_out_pos;

    // ------------------------------------------------------------------
    // RAM: word = {pattern byte, failure link}
    // ------------------------------------------------------------------
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [DW-1:0]        w_wdata;
    logic [AW-1:0]        w_raddr;
    logic [DW-1:0]        w_rdata;

    kmpss_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_PATTERN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    logic [BYTE_W-1:0]    w_rd_byte;
    logic signed [LW-1:0] w_rd_link;
    logic                 w_hit;
    logic                 w_walk_done;
    logic [LENW-1:0]      w_kk;       // walk result plus one
    logic [POS_W-1:0]     w_match_pos;

    assign w_rd_byte   = w_rdata[DW-1 -: BYTE_W];
    assign w_rd_link   = w_rdata[LW-1:0];
    assign w_hit       = (w_rd_byte == r_cmp_byte);
    assign w_walk_done = w_hit || w_rd_link[LW-1];
    assign w_kk        = w_hit ? (LENW'(r_k) + LENW'(1)) : '0;
    assign w_match_pos = r_tpos - POS_W'(r_len);

    // ------------------------------------------------------------------
    // Input handshake
    // ------------------------------------------------------------------
    t_op  w_op;
    logic w_take;
    logic w_slot_free;
    logic w_imm_result;

    assign w_op        = t_op'(i_op);
    assign w_slot_free = !r_out_valid || i_ready;

    // Items that decide a result in their accept cycle need the output slot.
    always_comb begin
        unique case (w_op)
            OP_CLEAR:  w_imm_result = 1'b0;
            OP_APPEND: w_imm_result = (r_len == LEN_FULL);
            OP_TEXT:   w_imm_result = !r_reported && (r_len == '0);
            OP_END:    w_imm_result = !r_reported;
            default:   w_imm_result = 1'b0;
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && (w_slot_free || !w_imm_result);
    assign w_take  = i_valid && o_ready;

    // Read address: the first walk index on accept, then the link just read.
    always_comb begin
        unique case (r_state)
            S_IDLE:  w_raddr = (w_op == OP_APPEND) ? r_build[AW-1:0] : r_match;
            S_CMP:   w_raddr = w_rd_link[AW-1:0];
            default: w_raddr = r_k;
        endcase
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_build      = r_build;
        n_match      = r_match;
        n_tpos       = r_tpos;
        n_reported   = r_reported;
        n_last_byte  = r_last_byte;
        n_cmp_byte   = r_cmp_byte;
        n_new_byte   = r_new_byte;
        n_is_append  = r_is_append;
        n_k          = r_k;
        n_found_pos  = r_found_pos;
        n_out_valid  = r_out_valid && !i_ready;   // drop once transferred
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        w_we         = 1'b0;
        w_waddr      = r_len[AW-1:0];
        w_wdata      = {i_data_byte, LINK_NONE};

        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    unique case (w_op)
                        OP_CLEAR: begin
                            n_len      = '0;
                            n_build    = LINK_NONE;
                            n_match    = '0;
                            n_tpos     = '0;
                            n_reported = 1'b0;
                        end
                        OP_APPEND: begin
                            if (r_len == LEN_FULL) begin
                                // drop the byte, report overflow
                                n_out_valid  = 1'b1;
                                n_out_status = ST_OVERFLOW;
                                n_out_pos    = '0;
                            end else begin
                                n_last_byte = i_data_byte;
                                n_match     = '0;
                                n_tpos      = '0;
                                n_reported  = 1'b0;
                                if (r_len == '0) begin
                                    w_we    = 1'b1;
                                    w_wdata = {i_data_byte, LINK_NONE};
                                    n_build = LINK_NONE;
                                    n_len   = r_len + LENW'(1);
                                end else if (r_build[LW-1]) begin
                                    // walk starts at the root: link is zero
                                    w_we    = 1'b1;
                                    w_wdata = {i_data_byte, LW'(0)};
                                    n_build = '0;
                                    n_len   = r_len + LENW'(1);
                                end else begin
                                    n_cmp_byte  = r_last_byte;
                                    n_new_byte  = i_data_byte;
                                    n_k         = r_build[AW-1:0];
                                    n_is_append = 1'b1;
                                    n_state     = S_CMP;
                                end
                            end
                        end
                        OP_TEXT: begin
                            if (!r_reported) begin
                                if (r_len == '0) begin
                                    n_reported   = 1'b1;
                                    n_out_valid  = 1'b1;
                                    n_out_status = ST_FOUND;
                                    n_out_pos    = '0;
                                end else begin
                                    n_tpos      = (r_tpos == POS_MAX) ? r_tpos
                                                                      : r_tpos + POS_W'(1);
                                    n_cmp_byte  = i_data_byte;
                                    n_k         = r_match;
                                    n_is_append = 1'b0;
                                    n_state     = S_CMP;
                                end
                            end
                        end
                        OP_END: begin
                            n_match    = '0;
                            n_tpos     = '0;
                            n_reported = 1'b0;
                            if (!r_reported) begin
                                n_out_valid  = 1'b1;
                                n_out_status = (r_len == '0) ? ST_FOUND : ST_NOT_FOUND;
                                n_out_pos    = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_CMP: begin
                if (!w_walk_done) begin
                    // advance along the failure chain
                    n_k = w_rd_link[AW-1:0];
                end else if (r_is_append) begin
                    w_we    = 1'b1;
                    w_wdata = {r_new_byte, LW'(w_kk)};
                    n_build = LW'(w_kk);
                    n_len   = r_len + LENW'(1);
                    n_state = S_IDLE;
                end else if (w_kk >= r_len) begin
                    n_reported = 1'b1;
                    n_match    = '0;
                    if (w_slot_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_FOUND;
                        n_out_pos    = w_match_pos;
                        n_state      = S_IDLE;
                    end else begin
                        // hold the position until the output slot frees
                        n_found_pos = w_match_pos;
                        n_state     = S_WAIT;
                    end
                end else begin
                    n_match = w_kk[AW-1:0];
                    n_state = S_IDLE;
                end
            end

            S_WAIT: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_FOUND;
                    n_out_pos    = r_found_pos;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_build     <= LINK_NONE;
            r_match     <= '0;
            r_tpos      <= '0;
            r_reported  <= 1'b0;
            r_is_append <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_build     <= n_build;
            r_match     <= n_match;
            r_tpos      <= n_tpos;
            r_reported  <= n_reported;
            r_is_append <= n_is_append;
            r_out_valid <= n_out_valid;
        end
        r_last_byte  <= n_last_byte;
        r_cmp_byte   <= n_cmp_byte;
        r_new_byte   <= n_new_byte;
        r_k          <= n_k;
        r_found_pos  <= n_found_pos;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_position = r_out_pos;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `KSS_ASSERT_NOW(a_match_below_len, (r_len == '0) || (LENW'(r_match) < r_len), "match prefix reached pattern length")
    `KSS_ASSERT_NOW(a_build_below_len, (r_len == '0) || r_build[LW-1] || (LENW'(r_build[AW-1:0]) < r_len), "build prefix reached pattern length")
    `KSS_ASSERT_NOW(a_wait_reported, (r_state != S_WAIT) || r_reported, "pending match without reported flag")
    `KSS_ASSERT_NEXT(a_write_grows, w_we, r_len == $past(r_len) + LENW'(1), "table write did not extend the pattern")

endmodule

>>> sim/kmp_substring_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_substring_search_checker
// Watches the item and result channels of the substring search, tracks the
// pattern, failure links and match state of its own, and compares every
// result transfer field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module kmp_substring_search_checker
    import kmpss_pkg::*;
#(
    parameter int PAT_CAP = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [BYTE_W-1:0]   i_data_byte,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [POS_W-1:0]    i_position,
    output int                  o_failures,
    output int                  o_pending,
    output int                  o_active_items
);

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] position;
    } t_search_result;

    t_search_result     search_results_q[$];

    logic [BYTE_W-1:0]  pat_bytes [PAT_CAP];
    int                 fail_link [PAT_CAP];
    int                 pat_len;
    int                 link_k;
    int                 match_k;
    logic [POS_W-1:0]   text_pos;
    bit                 reported;

    int                 failures     = 0;
    int                 active_items = 0;

    assign o_failures     = failures;
    assign o_pending      = search_results_q.size();
    assign o_active_items = active_items;

    function automatic int follow_links(int k, logic [BYTE_W-1:0] c);
        while (k >= 0 && k < PAT_CAP && pat_bytes[k] != c)
            k = fail_link[k];
        return k;
    endfunction

    function void restart_search();
        match_k  = 0;
        text_pos = '0;
        reported = 1'b0;
    endfunction

    task automatic apply_item(t_op kind, logic [BYTE_W-1:0] c);
        int             k;
        int             n;
        bit             emit;
        t_search_result res;
        emit = 1'b0;
        res.status   = ST_FOUND;
        res.position = '0;
        case (kind)
            OP_CLEAR: begin
                pat_len = 0;
                link_k  = -1;
                restart_search();
            end
            OP_APPEND: begin
                if (pat_len >= PAT_CAP) begin
                    // drop the byte, keep everything else
                    emit       = 1'b1;
                    res.status = ST_OVERFLOW;
                end else begin
                    n = pat_len;
                    pat_bytes[n] = c;
                    if (n == 0) begin
                        fail_link[0] = -1;
                        link_k       = -1;
                    end else begin
                        k            = follow_links(link_k, pat_bytes[n-1]) + 1;
                        fail_link[n] = k;
                        link_k       = k;
                    end
                    pat_len = n + 1;
                    restart_search();
                end
            end
            OP_TEXT: begin
                if (!reported) begin
                    if (pat_len == 0) begin
                        reported = 1'b1;
                        emit     = 1'b1;
                    end else begin
                        if (text_pos != POS_MAX)
                            text_pos = text_pos + 1'b1;
                        k = follow_links(match_k, c) + 1;
                        if (k >= pat_len) begin
                            reported     = 1'b1;
                            match_k      = 0;
                            emit         = 1'b1;
                            res.position = text_pos - POS_W'(pat_len);
                        end else begin
                            match_k = k;
                        end
                    end
                end
            end
            default: begin
                if (!reported) begin
                    emit       = 1'b1;
                    res.status = (pat_len == 0) ? ST_FOUND : ST_NOT_FOUND;
                end
                restart_search();
            end
        endcase
        if (emit)
            search_results_q.push_back(res);
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_search_result want;
        if (!i_rst_n) begin
            pat_len = 0;
            link_k  = -1;
            restart_search();
            search_results_q.delete();
        end else begin
            // results first: a result never belongs to an item of this edge
            if (i_out_valid && i_out_ready) begin
                if (search_results_q.size() == 0) begin
                    $error("unexpected result: status %0d position %0d",
                           i_status, i_position);
                    failures++;
                end else begin
                    want = search_results_q.pop_front();
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d actual %0d",
                               want.status, i_status);
                        failures++;
                    end
                    if (i_position !== want.position) begin
                        $error("position mismatch: expected %0d actual %0d",
                               want.position, i_position);
                        failures++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                active_items++;
                apply_item(t_op'(i_op), i_data_byte);
            end
        end
    end

endmodule

>>> sim/kmp_substring_search_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_substring_search_top_tb
// Drives pattern builds, texts and stray items into the substring search,
// with idle and stall phases on both channels; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module kmp_substring_search_top_tb;
    import kmpss_pkg::*;

    localparam int PAT_CAP     = 64;
    localparam int ITEM_TARGET = 550;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        t_op               kind;
        logic [BYTE_W-1:0] b;
    } t_script_item;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     op        = OP_CLEAR;
    logic [BYTE_W-1:0]   data_byte = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;

    int failures;
    int pending;
    int active_items;

    // idle and stall odds in percent, changed per phase
    int idle_pct  = 0;
    int stall_pct = 0;

    int idle_tab  [4] = '{0, 64, 0, 7};
    int stall_tab [4] = '{0, 0, 64, 7};

    // Directed opening: empty pattern, report then ignore, links that fall
    // back, append after a report, and not found.
    t_script_item script [25] = '{
        '{OP_END,    8'h00}, '{OP_TEXT,   8'hFF}, '{OP_TEXT,   8'h00},
        '{OP_END,    8'h00}, '{OP_APPEND, 8'h00}, '{OP_APPEND, 8'hFF},
        '{OP_APPEND, 8'h00}, '{OP_TEXT,   8'h00}, '{OP_TEXT,   8'h00},
        '{OP_TEXT,   8'hFF}, '{OP_TEXT,   8'h00}, '{OP_TEXT,   8'hFF},
        '{OP_END,    8'hFF}, '{OP_TEXT,   8'h00}, '{OP_END,    8'h00},
        '{OP_CLEAR,  8'hFF}, '{OP_APPEND, 8'hA5}, '{OP_APPEND, 8'hA5},
        '{OP_TEXT,   8'hA5}, '{OP_TEXT,   8'h5A}, '{OP_TEXT,   8'hA5},
        '{OP_TEXT,   8'hA5}, '{OP_END,    8'h00}, '{OP_APPEND, 8'h5A},
        '{OP_END,    8'h00}
    };

    kmp_substring_search_top #(
        .MAX_PATTERN (PAT_CAP)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_op        (op),
        .i_data_byte (data_byte),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_status    (status),
        .o_position  (position)
    );

    kmp_substring_search_checker #(
        .PAT_CAP (PAT_CAP)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_op           (op),
        .i_data_byte    (data_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_status       (status),
        .i_position     (position),
        .o_failures     (failures),
        .o_pending      (pending),
        .o_active_items (active_items)
    );

    // 2 ns clock
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Result side: stall at random with the odds of the current phase.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one item and hold it until the transfer. Idle cycles come
    // before the item, so valid never drops while an item is pending.
    task automatic send_item(t_op kind, logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= kind;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // One well-formed search: optional clear, a pattern over a small
    // alphabet, a text over the same alphabet that may carry the pattern,
    // and usually an end of text. Appends past the capacity give overflow.
    task automatic run_search(int plen, int tlen, bit do_clear, bit embed);
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] sym;
        int                span;
        int                at;
        logic [BYTE_W-1:0] pat_copy [$];
        base = BYTE_W'($urandom_range(255));
        span = $urandom_range(1, 3);
        at   = embed ? int'($urandom_range(tlen)) : -1;
        if (do_clear)
            send_item(OP_CLEAR, BYTE_W'($urandom_range(255)));
        for (int i = 0; i < plen; i++) begin
            sym = base + BYTE_W'($urandom_range(span - 1));
            if (i < PAT_CAP)
                pat_copy.push_back(sym);
            send_item(OP_APPEND, sym);
        end
        for (int i = 0; i <= tlen; i++) begin
            if (i == at) begin
                foreach (pat_copy[j])
                    send_item(OP_TEXT, pat_copy[j]);
            end
            if (i < tlen)
                send_item(OP_TEXT, base + BYTE_W'($urandom_range(span - 1)));
        end
        if ($urandom_range(9) != 0)
            send_item(OP_END, BYTE_W'($urandom_range(255)));
    endtask

    // Hard limit on the run time.
    initial begin
        #2_000_000;
        $display("kmp_substring_search_top_tb failed");
        $finish;
    end

    initial begin : stimulus
        int r;
        // hold reset at the start, then release it for good
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_item(script[i].kind, script[i].b);

        // Random part in four phases: no idling, sender idle, receiver
        // stalling, both idling a little.
        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            while (active_items < (p + 1) * ITEM_TARGET / 4) begin
                r = $urandom_range(99);
                if (r < 68) begin
                    run_search($urandom_range(0, 6), $urandom_range(0, 30),
                               $urandom_range(9) != 0, 1'($urandom_range(1)));
                end else if (r < 74) begin
                    // fill the pattern to capacity and at times push past it
                    run_search(PAT_CAP + $urandom_range(0, 3),
                               $urandom_range(0, 12), 1'b1, 1'b1);
                end else if (r < 82) begin
                    run_search($urandom_range(7, PAT_CAP - 1),
                               $urandom_range(0, 20), 1'b1, 1'($urandom_range(1)));
                end else begin
                    // stray items with fully random codes and bytes
                    repeat ($urandom_range(1, 8))
                        send_item(t_op'($urandom_range(3)), BYTE_W'($urandom_range(255)));
                end
            end
        end
        in_valid <= 1'b0;

        // let the checker see the last transfer, then drain the results
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0) begin
            $display("kmp_substring_search_top_tb passed");
        end else begin
            $display("kmp_substring_search_top_tb failed");
        end
        $finish;
    end

endmodule
